>>> hw/rtl/scfr_pkg.sv
// Shared types and constants of the serial command framer.
package scfr_pkg;
    localparam int PAYLOAD_WORDS = 12;
    localparam int WIDX_W = 4;
    localparam int BIDX_W = 6;
    localparam logic [7:0] LEN_DATA = 8'(2 * PAYLOAD_WORDS);

    typedef enum logic [2:0] {
        CMD_TICK = 3'd0, CMD_LOAD = 3'd1, CMD_START = 3'd2, CMD_SHUT = 3'd3,
        CMD_SIM = 3'd4, CMD_THR = 3'd5, CMD_DATA = 3'd6, CMD_REPLY = 3'd7
    } t_cmd;

    // Pending reply codes double as frame codes.
    localparam logic [2:0] PR_IDLE = 3'd0;
    localparam logic [2:0] PR_START = 3'd1;
    localparam logic [2:0] PR_SHUT = 3'd2;
    localparam logic [2:0] PR_SIM = 3'd3;
    localparam logic [2:0] PR_DATA = 3'd4;
    localparam logic [2:0] PR_THR = 3'd5;

    localparam logic [3:0] EV_STARTED = 4'd6;
    localparam logic [3:0] EV_SHUTDOWN = 4'd7;
    localparam logic [3:0] EV_ERROR = 4'd8;

    localparam logic [1:0] CFG_LIMIT = 2'd0;
    localparam logic [1:0] CFG_RTO = 2'd1;
    localparam logic [1:0] CFG_FTO = 2'd2;
    localparam logic [1:0] CFG_ADDR = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  word_index;
        logic [15:0] word_value;
        logic [7:0]  percent;
        logic        got_ok;
        logic        got_error_reply;
        logic        got_end;
    } t_in;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic [3:0] event_res;
        logic       last;
    } t_out;

    // One job for the back end: up to three steps in order; the frame may go out twice.
    typedef struct packed {
        logic       ev1_on;
        logic [3:0] ev1;
        logic       fr_on;
        logic [2:0] fr;
        logic       fr_twice;
        logic [7:0] pct;
        logic       ev2_on;
        logic [3:0] ev2;
    } t_job;

    typedef enum logic [1:0] {
        BS_IDLE, BS_EV1, BS_FRAME, BS_EV2
    } t_bstate;

    function automatic logic [7:0] op_of(input logic [2:0] c);
        unique case (c)
            PR_START: op_of = 8'h04;
            PR_SHUT:  op_of = 8'h03;
            PR_SIM:   op_of = 8'h02;
            PR_DATA:  op_of = 8'h05;
            default:  op_of = 8'h06;
        endcase
    endfunction
endpackage

>>> hw/rtl/scfr_front.sv
// Front end: protocol state, timers, payload store and job building.
module scfr_front import scfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    input  t_in         i_req,
    output logic        o_stall,
    output logic        o_job_valid,
    output t_job        o_job,
    input  logic        i_q_full,
    input  logic        i_back_busy,
    input  logic [WIDX_W-1:0] i_rd_idx,
    output logic [15:0] o_rd_word,
    output logic [7:0]  o_addr
);
    logic [3:0]  r_limit;
    logic [15:0] r_rto, r_fto;
    logic [7:0]  r_addr;
    logic [2:0]  r_pr, n_pr;
    logic [1:0]  r_pf, n_pf;
    logic [4:0]  r_retry, n_retry;
    logic [15:0] r_rt, n_rt, r_ft, n_ft;
    logic        r_rt_on, n_rt_on, r_ft_on, n_ft_on;
    logic [15:0] r_store [PAYLOAD_WORDS];
    logic [PAYLOAD_WORDS-1:0] r_sv;
    logic [15:0] rt_inc, ft_inc;
    logic [15:0] rto_e, fto_e;
    logic [4:0]  retry_i;
    t_job        job;
    logic        acc;

    // Hold new requests while the back end may still read the payload store.
    assign o_stall = i_q_full || i_back_busy;
    assign acc = i_valid && !o_stall;
    assign o_addr = r_addr;
    assign o_rd_word = r_sv[i_rd_idx] ? r_store[i_rd_idx] : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 4'd3; r_rto <= 16'd1000; r_fto <= 16'd10000; r_addr <= 8'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIMIT: r_limit <= i_cfg_data[3:0];
                CFG_RTO:   r_rto <= i_cfg_data;
                CFG_FTO:   r_fto <= i_cfg_data;
                default:   r_addr <= i_cfg_data[7:0];
            endcase
        end
    end

    always_comb begin
        n_pr = r_pr; n_pf = r_pf; n_retry = r_retry;
        n_rt = r_rt; n_rt_on = r_rt_on; n_ft = r_ft; n_ft_on = r_ft_on;
        job = '0;
        rto_e = (r_rto == 16'd0) ? 16'd1 : r_rto;
        fto_e = (r_fto == 16'd0) ? 16'd1 : r_fto;
        rt_inc = (r_rt == 16'hFFFF) ? r_rt : r_rt + 16'd1;
        ft_inc = (r_ft == 16'hFFFF) ? r_ft : r_ft + 16'd1;
        retry_i = r_retry;
        unique case (t_cmd'(i_req.cmd))
            CMD_TICK: begin
                if (r_rt_on) begin
                    n_rt = rt_inc;
                    if (rt_inc >= rto_e) begin
                        n_rt_on = 1'b0; n_rt = '0;
                        job.ev1_on = 1'b1; job.ev1 = EV_ERROR;
                    end
                end
                if (r_ft_on) begin
                    n_ft = ft_inc;
                    if (ft_inc >= fto_e) begin
                        n_ft_on = 1'b0; n_ft = '0;
                        job.ev2_on = 1'b1; job.ev2 = EV_ERROR;
                    end
                end
            end
            CMD_LOAD: ;
            CMD_REPLY: begin
                if (i_req.got_ok) begin
                    retry_i = '0; n_rt_on = 1'b0; n_rt = '0; n_pr = PR_IDLE;
                    if (r_pr != PR_IDLE) begin
                        job.ev1_on = 1'b1; job.ev1 = {1'b0, r_pr};
                    end
                    if (r_pr == PR_START || r_pr == PR_SHUT) begin
                        n_ft = '0; n_ft_on = 1'b1;
                    end
                    if (r_pr == PR_THR) begin
                        job.fr_on = 1'b1; job.fr = PR_DATA;
                        n_pr = PR_DATA; n_rt = '0; n_rt_on = 1'b1;
                    end
                end
                if (i_req.got_error_reply) begin
                    n_rt_on = 1'b0; n_rt = '0;
                    if (retry_i != 5'd31) retry_i = retry_i + 5'd1;
                    if (retry_i > {1'b0, r_limit}) begin
                        job.ev2_on = 1'b1; job.ev2 = EV_ERROR;
                    end else if (n_pr != PR_IDLE) begin
                        // An OK ahead of it leaves only the data frame pending, which
                        // has just been sent and now goes out a second time.
                        if (job.fr_on) job.fr_twice = 1'b1;
                        else begin
                            job.fr_on = 1'b1; job.fr = n_pr;
                        end
                        n_rt = '0; n_rt_on = 1'b1;
                    end
                end
                if (i_req.got_end && !(i_req.got_error_reply && retry_i > {1'b0, r_limit})) begin
                    n_ft_on = 1'b0; n_ft = '0;
                    if (r_pf != 2'd0) begin
                        job.ev2_on = 1'b1;
                        job.ev2 = (r_pf == 2'd1) ? EV_STARTED : EV_SHUTDOWN;
                        n_pf = 2'd0;
                    end
                end
                n_retry = retry_i;
            end
            default: begin
                if (r_pr == PR_IDLE) begin
                    job.fr_on = 1'b1; n_rt = '0; n_rt_on = 1'b1;
                    unique case (t_cmd'(i_req.cmd))
                        CMD_START: begin job.fr = PR_START; n_pf = 2'd1; end
                        CMD_SHUT:  begin job.fr = PR_SHUT; n_pf = 2'd2; end
                        CMD_SIM:   job.fr = PR_SIM;
                        CMD_THR:   job.fr = PR_THR;
                        default:   job.fr = PR_DATA;
                    endcase
                    n_pr = job.fr;
                end
            end
        endcase
    end

    // The threshold byte rides with each job; the saved copy feeds resends.
    logic [7:0] r_pct;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr <= PR_IDLE; r_pf <= '0; r_retry <= '0;
            r_rt <= '0; r_rt_on <= 1'b0; r_ft <= '0; r_ft_on <= 1'b0;
            r_sv <= '0; r_pct <= '0;
        end else if (acc) begin
            r_pr <= n_pr; r_pf <= n_pf; r_retry <= n_retry;
            r_rt <= n_rt; r_rt_on <= n_rt_on; r_ft <= n_ft; r_ft_on <= n_ft_on;
            if (i_req.cmd == CMD_LOAD && i_req.word_index < WIDX_W'(PAYLOAD_WORDS)) begin
                r_sv[i_req.word_index] <= 1'b1;
                r_store[i_req.word_index] <= i_req.word_value;
            end
            if (i_req.cmd == CMD_THR && r_pr == PR_IDLE) r_pct <= i_req.percent;
        end
    end

    always_comb begin
        o_job = job;
        o_job.pct = (i_req.cmd == CMD_THR && r_pr == PR_IDLE) ? i_req.percent : r_pct;
    end
    assign o_job_valid = acc;
endmodule

>>> hw/rtl/scfr_queue.sv
// Two-entry job queue between front and back end.
module scfr_queue import scfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);
    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    assign o_full = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job = r_mem[r_rp];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) begin r_mem[r_wp] <= i_job; r_wp <= ~r_wp; end
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

>>> hw/rtl/scfr_back.sv
// Back end: emits events and frame bytes of one job at a time.
module scfr_back import scfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_busy,
    output logic [WIDX_W-1:0] o_rd_idx,
    input  logic [15:0] i_rd_word,
    input  logic [7:0]  i_addr,
    output logic        o_valid,
    output t_out        o_res,
    input  logic        i_stall
);
    t_bstate r_st, n_st;
    logic [BIDX_W-1:0] r_bi, n_bi;
    logic [7:0] r_chk, n_chk;
    logic r_v, n_v;
    logic r_rep, n_rep;
    t_out r_res, n_res;
    logic [7:0] op, len, bval, nbytes;
    logic is_data, go, fin, has_next_frame, has_next_ev2;

    assign o_valid = r_v;
    assign o_res = r_res;
    assign o_busy = (r_st != BS_IDLE) || !i_empty;
    assign go = !r_v || !i_stall;
    assign op = op_of(i_job.fr);
    assign is_data = (i_job.fr == PR_DATA);
    assign len = is_data ? LEN_DATA : 8'd1;
    assign nbytes = len + 8'd7;
    assign o_rd_idx = WIDX_W'((r_bi - BIDX_W'(5)) >> 1);
    assign has_next_frame = i_job.fr_on;
    assign has_next_ev2 = i_job.ev2_on;

    always_comb begin
        priority case (1'b1)
            r_bi == BIDX_W'(0): bval = 8'h2A;
            r_bi == BIDX_W'(1): bval = 8'hEB;
            r_bi == BIDX_W'(2): bval = i_addr;
            r_bi == BIDX_W'(3): bval = op;
            r_bi == BIDX_W'(4): bval = len;
            8'(r_bi) == nbytes - 8'd2: bval = r_chk;
            8'(r_bi) == nbytes - 8'd1: bval = 8'hAD;
            is_data: bval = r_bi[0] ? i_rd_word[15:8] : i_rd_word[7:0];
            i_job.fr == PR_THR: bval = i_job.pct;
            default: bval = 8'h00;
        endcase
    end

    always_comb begin
        n_st = r_st; n_bi = r_bi; n_chk = r_chk; n_res = r_res; n_rep = r_rep;
        n_v = r_v && i_stall; o_pop = 1'b0; fin = 1'b0;
        if (go) begin
            unique case (r_st)
                BS_IDLE: begin
                    if (!i_empty) begin
                        n_bi = '0; n_chk = '0; n_rep = 1'b0;
                        if (i_job.ev1_on) n_st = BS_EV1;
                        else if (i_job.fr_on) n_st = BS_FRAME;
                        else if (i_job.ev2_on) n_st = BS_EV2;
                        else o_pop = 1'b1;
                    end
                end
                BS_EV1: begin
                    n_v = 1'b1;
                    n_res = '{kind: 1'b1, tx_byte: 8'h00, event_res: i_job.ev1,
                              last: !(has_next_frame || has_next_ev2)};
                    if (has_next_frame) n_st = BS_FRAME;
                    else if (has_next_ev2) n_st = BS_EV2;
                    else fin = 1'b1;
                end
                BS_FRAME: begin
                    n_v = 1'b1;
                    n_res = '{kind: 1'b0, tx_byte: bval, event_res: 4'd0, last: 1'b0};
                    if (r_bi >= BIDX_W'(2) && 8'(r_bi) < nbytes - 8'd2)
                        n_chk = r_chk ^ bval;
                    n_bi = r_bi + BIDX_W'(1);
                    if (8'(r_bi) == nbytes - 8'd1) begin
                        // A repeated frame starts over from its first byte.
                        if (i_job.fr_twice && !r_rep) begin
                            n_bi = '0; n_chk = '0; n_rep = 1'b1;
                        end else if (has_next_ev2) n_st = BS_EV2;
                        else begin n_res.last = 1'b1; fin = 1'b1; end
                    end
                end
                default: begin
                    n_v = 1'b1;
                    n_res = '{kind: 1'b1, tx_byte: 8'h00, event_res: i_job.ev2, last: 1'b1};
                    fin = 1'b1;
                end
            endcase
            if (fin) begin n_st = BS_IDLE; o_pop = 1'b1; end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BS_IDLE; r_v <= 1'b0; r_bi <= '0; r_chk <= '0; r_rep <= 1'b0;
        end else begin
            r_st <= n_st; r_v <= n_v; r_bi <= n_bi; r_chk <= n_chk; r_rep <= n_rep;
        end
    end
    always_ff @(posedge i_clk) r_res <= n_res;
endmodule

>>> hw/rtl/serial_command_framer_with_retry.sv
// Top level of the serial command framer with retry.
// Accepted jobs are registered in the job queue; the back end then registers each result.
// The single byte emitter of the back end gives one result per cycle while the receiver
// does not stall; the data frame is 31 bytes long, the other frames 8.
// Requests are held off while the back end has work, so one request is in flight at a time.
// Reset is synchronous, active low, and restores register defaults and a cleared payload.
module serial_command_framer_with_retry import scfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_req,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_res
);
    // The front end decides protocol state; jobs describe the results to emit.
    t_job f_job, q_job;
    logic f_v, q_full, q_empty, q_pop, b_busy;
    logic [WIDX_W-1:0] rd_idx;
    logic [15:0] rd_word;
    logic [7:0] addr;

    scfr_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_req, .o_stall,
        .o_job_valid(f_v), .o_job(f_job), .i_q_full(q_full), .i_back_busy(b_busy),
        .i_rd_idx(rd_idx), .o_rd_word(rd_word), .o_addr(addr)
    );

    scfr_queue u_queue (
        .i_clk, .i_rst_n, .i_push(f_v && (f_job.ev1_on || f_job.fr_on || f_job.ev2_on)),
        .i_job(f_job), .o_full(q_full), .i_pop(q_pop), .o_empty(q_empty), .o_job(q_job)
    );

    // The back end owns the output register and never drops a stalled result.
    scfr_back u_back (
        .i_clk, .i_rst_n, .i_empty(q_empty), .i_job(q_job), .o_pop(q_pop),
        .o_busy(b_busy), .o_rd_idx(rd_idx), .i_rd_word(rd_word), .i_addr(addr),
        .o_valid, .o_res, .i_stall
    );
endmodule

>>> tb/testbench.sv
// Self-checking testbench of the serial command framer with retry.
`timescale 1ns / 100ps

module testbench;
    import scfr_pkg::*;

    localparam int N_RANDOM = 220;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in         i_req = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out        o_res;

    serial_command_framer_with_retry dut (.*);

    always #10 i_clk = ~i_clk;

    // Predictor state: registers and link state of the framer.
    logic [3:0]  lim_r;
    logic [15:0] rto_r, fto_r;
    logic [7:0]  addr_r;
    logic [2:0]  pend_reply;
    logic [1:0]  pend_finish;
    logic [4:0]  retries;
    logic [15:0] rtimer, ftimer;
    logic        rtimer_on, ftimer_on;
    logic [15:0] words [PAYLOAD_WORDS];
    logic [7:0]  pct_r;

    t_out expected_q [$];
    t_out step_q [$];
    int   errors = 0;
    logic long_hold = 1'b0;

    task automatic push_res(input logic k, input logic [7:0] b, input logic [3:0] e);
        t_out r;
        if (step_q.size() >= 64) return;
        r.kind = k; r.tx_byte = b; r.event_res = e; r.last = 1'b0;
        step_q.push_back(r);
    endtask

    task automatic emit_frame(input logic [2:0] code);
        logic [7:0] op, len, chk, d;
        case (code)
            PR_START: op = 8'h04;
            PR_SHUT:  op = 8'h03;
            PR_SIM:   op = 8'h02;
            PR_DATA:  op = 8'h05;
            default:  op = 8'h06;
        endcase
        len = (code == PR_DATA) ? LEN_DATA : 8'd1;
        push_res(0, 8'h2A, 0); push_res(0, 8'hEB, 0);
        push_res(0, addr_r, 0); push_res(0, op, 0); push_res(0, len, 0);
        chk = addr_r ^ op ^ len;
        if (code == PR_DATA) begin
            for (int i = 0; i < PAYLOAD_WORDS; i++) begin
                push_res(0, words[i][15:8], 0);
                push_res(0, words[i][7:0], 0);
                chk = chk ^ words[i][15:8] ^ words[i][7:0];
            end
        end else begin
            d = (code == PR_THR) ? pct_r : 8'd0;
            push_res(0, d, 0);
            chk = chk ^ d;
        end
        push_res(0, chk, 0); push_res(0, 8'hAD, 0);
        rtimer = 0; rtimer_on = 1;
    endtask

    task automatic handle_reply(input logic ok, input logic er, input logic en);
        logic [2:0] p;
        if (ok) begin
            p = pend_reply;
            retries = 0; rtimer_on = 0; rtimer = 0; pend_reply = PR_IDLE;
            if (p == PR_START || p == PR_SHUT) begin
                ftimer = 0; ftimer_on = 1; push_res(1, 0, {1'b0, p});
            end else if (p == PR_SIM || p == PR_DATA) begin
                push_res(1, 0, {1'b0, p});
            end else if (p == PR_THR) begin
                push_res(1, 0, {1'b0, p});
                emit_frame(PR_DATA);
                pend_reply = PR_DATA;
            end
        end
        if (er) begin
            rtimer_on = 0; rtimer = 0;
            if (retries < 31) retries++;
            if (retries > lim_r) begin
                push_res(1, 0, EV_ERROR);
                return;
            end
            if (pend_reply != PR_IDLE) emit_frame(pend_reply);
        end
        if (en) begin
            ftimer_on = 0; ftimer = 0;
            if (pend_finish == 2'd1) begin
                pend_finish = 0; push_res(1, 0, EV_STARTED);
            end else if (pend_finish == 2'd2) begin
                pend_finish = 0; push_res(1, 0, EV_SHUTDOWN);
            end
        end
    endtask

    // Works out every result one request causes and queues them.
    task automatic predict_request(input t_in q);
        step_q = {};
        case (t_cmd'(q.cmd))
            CMD_TICK: begin
                if (rtimer_on) begin
                    if (rtimer != 16'hFFFF) rtimer++;
                    if (rtimer >= rto_r) begin
                        rtimer_on = 0; rtimer = 0; push_res(1, 0, EV_ERROR);
                    end
                end
                if (ftimer_on) begin
                    if (ftimer != 16'hFFFF) ftimer++;
                    if (ftimer >= fto_r) begin
                        ftimer_on = 0; ftimer = 0; push_res(1, 0, EV_ERROR);
                    end
                end
            end
            CMD_LOAD: if (q.word_index < PAYLOAD_WORDS) words[q.word_index] = q.word_value;
            CMD_REPLY: handle_reply(q.got_ok, q.got_error_reply, q.got_end);
            default: begin
                if (pend_reply == PR_IDLE) begin
                    case (t_cmd'(q.cmd))
                        CMD_START: begin
                            pend_finish = 1; emit_frame(PR_START); pend_reply = PR_START;
                        end
                        CMD_SHUT: begin
                            pend_finish = 2; emit_frame(PR_SHUT); pend_reply = PR_SHUT;
                        end
                        CMD_SIM: begin
                            emit_frame(PR_SIM); pend_reply = PR_SIM;
                        end
                        CMD_THR: begin
                            pct_r = q.percent; emit_frame(PR_THR); pend_reply = PR_THR;
                        end
                        default: begin
                            emit_frame(PR_DATA); pend_reply = PR_DATA;
                        end
                    endcase
                end
            end
        endcase
        if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LIMIT: lim_r = val[3:0];
            CFG_RTO:   rto_r = val;
            CFG_FTO:   fto_r = val;
            default:   addr_r = val[7:0];
        endcase
    endtask

    // Waits for every expected result, then lets the back end settle.
    task automatic drain;
        while (expected_q.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Offers one request and holds it until accepted; predicts at acceptance.
    task automatic send_request(input t_in q);
        i_req <= q; i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_request(q);
    endtask

    int gap_left = 0;
    task automatic send_paced(input t_in q);
        if (gap_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            gap_left = $urandom_range(1, 12);
        end
        send_request(q);
        gap_left--;
    endtask

    function automatic t_in mk(input t_cmd c, input logic [3:0] wi, input logic [15:0] wv,
                               input logic [7:0] pc, input logic [2:0] oke);
        t_in q;
        q.cmd = c; q.word_index = wi; q.word_value = wv; q.percent = pc;
        q.got_ok = oke[2]; q.got_error_reply = oke[1]; q.got_end = oke[0];
        return q;
    endfunction

    // Random request, mostly well-formed: commands, loads, replies and ticks.
    function automatic t_in rand_req();
        t_in q;
        int r;
        q = t_in'(34'({$urandom, $urandom}));
        r = $urandom_range(0, 99);
        if (r < 25) q.cmd = CMD_REPLY;
        else if (r < 45) q.cmd = CMD_TICK;
        else if (r < 60) begin
            q.cmd = CMD_LOAD;
            if ($urandom_range(0, 9) != 0) q.word_index = 4'($urandom_range(0, 11));
        end else q.cmd = 3'($urandom_range(2, 6));
        return q;
    endfunction

    // Receiver: random stall pattern, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else if (long_hold) i_stall <= 1'b1;
        else if ($urandom_range(0, 3) == 0) i_stall <= ($urandom_range(0, 2) != 0);
        else i_stall <= 1'b0;
    end

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result kind=%0d tx_byte=%h event_res=%0d",
                       o_res.kind, o_res.tx_byte, o_res.event_res);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_res.kind !== e.kind) begin
                    $error("kind expected %0d actual %0d", e.kind, o_res.kind); errors++;
                end
                if (o_res.tx_byte !== e.tx_byte) begin
                    $error("tx_byte expected %h actual %h", e.tx_byte, o_res.tx_byte);
                    errors++;
                end
                if (o_res.event_res !== e.event_res) begin
                    $error("event_res expected %0d actual %0d", e.event_res, o_res.event_res);
                    errors++;
                end
                if (o_res.last !== e.last) begin
                    $error("last expected %0d actual %0d", e.last, o_res.last); errors++;
                end
            end
        end
    end

    // Directed table: each row is a request plus, where obvious, its single event.
    typedef struct {
        t_in        q;
        logic       has_ev;
        logic [3:0] ev;
    } t_row;

    t_row dir_rows [$];

    task automatic add_row(input t_in q, input logic h, input logic [3:0] e);
        t_row r;
        r.q = q; r.has_ev = h; r.ev = e;
        dir_rows.push_back(r);
    endtask

    initial begin
        int n;
        lim_r = 3; rto_r = 1000; fto_r = 10000; addr_r = 2;
        pend_reply = 0; pend_finish = 0; retries = 0;
        rtimer = 0; ftimer = 0; rtimer_on = 0; ftimer_on = 0; pct_r = 0;
        foreach (words[i]) words[i] = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Data frame straight after reset carries an all-zero payload.
        add_row(mk(CMD_DATA, 0, 0, 0, 3'b000), 0, 0);
        add_row(mk(CMD_START, 0, 0, 0, 3'b000), 0, 0);  // busy: ignored
        add_row(mk(CMD_REPLY, 0, 0, 0, 3'b100), 1, 4'd4);
        add_row(mk(CMD_LOAD, 0, 16'hFFFF, 0, 3'b000), 0, 0);
        add_row(mk(CMD_LOAD, 11, 16'h0000, 0, 3'b000), 0, 0);
        add_row(mk(CMD_LOAD, 5, 16'hA55A, 0, 3'b000), 0, 0);
        add_row(mk(CMD_LOAD, 15, 16'h1234, 0, 3'b000), 0, 0);  // out of range slot
        add_row(mk(CMD_THR, 0, 0, 8'hFF, 3'b000), 0, 0);
        add_row(mk(CMD_REPLY, 0, 0, 0, 3'b010), 0, 0);        // error reply: resend
        add_row(mk(CMD_REPLY, 0, 0, 0, 3'b100), 0, 0);        // ack then data frame
        add_row(mk(CMD_REPLY, 0, 0, 0, 3'b100), 1, 4'd4);
        add_row(mk(CMD_THR, 0, 0, 8'h3C, 3'b000), 0, 0);
        add_row(mk(CMD_REPLY, 0, 0, 0, 3'b110), 0, 0);        // ack, data frame twice
        add_row(mk(CMD_REPLY, 0, 0, 0, 3'b100), 1, 4'd4);
        add_row(mk(CMD_START, 0, 0, 0, 3'b000), 0, 0);
        add_row(mk(CMD_REPLY, 0, 0, 0, 3'b100), 1, 4'd1);
        add_row(mk(CMD_REPLY, 0, 0, 0, 3'b001), 1, EV_STARTED);
        add_row(mk(CMD_SHUT, 0, 0, 0, 3'b000), 0, 0);
        add_row(mk(CMD_REPLY, 0, 0, 0, 3'b111), 0, 0);        // all three at once
        add_row(mk(CMD_SIM, 0, 0, 0, 3'b000), 0, 0);
        add_row(mk(CMD_REPLY, 0, 0, 0, 3'b010), 0, 0);
        add_row(mk(CMD_REPLY, 0, 0, 0, 3'b010), 0, 0);
        add_row(mk(CMD_REPLY, 0, 0, 0, 3'b010), 0, 0);
        add_row(mk(CMD_REPLY, 0, 0, 0, 3'b011), 1, EV_ERROR);  // past the limit
        add_row(mk(CMD_REPLY, 0, 0, 0, 3'b100), 1, 4'd3);
        add_row(mk(CMD_REPLY, 0, 0, 0, 3'b111), 0, 0);        // all while idle
        add_row(mk(CMD_TICK, 0, 0, 0, 3'b000), 0, 0);

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].q);
            if (dir_rows[i].has_ev && !(step_q.size() == 1 && step_q[0].kind == 1'b1 &&
                                        step_q[0].event_res == dir_rows[i].ev)) begin
                $error("event_res expected %0d actual prediction differs", dir_rows[i].ev);
                errors++;
            end
        end
        i_valid <= 1'b0;
        drain();

        // Extreme settings: short timeouts, zero limit, full address.
        write_reg(CFG_LIMIT, 16'd0);
        write_reg(CFG_RTO, 16'd1);
        write_reg(CFG_FTO, 16'd1);
        write_reg(CFG_ADDR, 16'h00FF);
        send_request(mk(CMD_START, 0, 0, 0, 3'b000));
        send_request(mk(CMD_TICK, 0, 0, 0, 3'b000));  // reply timeout
        send_request(mk(CMD_REPLY, 0, 0, 0, 3'b010));
        send_request(mk(CMD_REPLY, 0, 0, 0, 3'b100));
        send_request(mk(CMD_TICK, 0, 0, 0, 3'b000));  // finish timeout
        i_valid <= 1'b0;
        drain();

        // Random phases under several settings; one with a long receiver hold-off.
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_LIMIT, 16'($urandom_range(0, 15)));
            write_reg(CFG_RTO, (ph == 3) ? 16'hFFFF : 16'($urandom_range(1, 8)));
            write_reg(CFG_FTO, (ph == 2) ? 16'hFFFF : 16'($urandom_range(1, 12)));
            write_reg(CFG_ADDR, 16'($urandom_range(0, 255)));
            n = 0;
            while (n < N_RANDOM / 4) begin
                if (ph == 1 && n == 10) begin
                    long_hold = 1'b1;
                    fork
                        begin
                            repeat (150) @(posedge i_clk);
                            long_hold = 1'b0;
                        end
                    join_none
                end
                if (ph == 2 && n == 20) begin
                    i_valid <= 1'b0;
                    while (expected_q.size() > 0) @(posedge i_clk);
                end
                send_paced(rand_req());
                n++;
            end
            i_valid <= 1'b0;
            drain();
        end

        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
